// ----- src/zrld_pkg.sv -----
package zrld_pkg;

    localparam int OFFSET_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH      = 4;
    localparam int VARINT_MAX_BYTES = 10;
    localparam int VARINT_STEP      = 7;
    localparam int HEADER_BYTES     = 8;
    localparam int M_TDATA_W        = 72;
    localparam int M_TUSER_W        = 5;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [1:0] KIND_LIT  = 2'd0;
    localparam logic [1:0] KIND_FILL = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_HEADER   = 3'd1;
    localparam logic [2:0] ERR_OVERLONG = 3'd2;
    localparam logic [2:0] ERR_ZERO_OVF = 3'd3;
    localparam logic [2:0] ERR_LIT_OVF  = 3'd4;
    localparam logic [2:0] ERR_SHORT    = 3'd5;
    localparam logic [2:0] ERR_TRUNC    = 3'd6;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  err;
        logic [31:0] offset;
        logic [31:0] count;
        logic [7:0]  data;
    } zrld_tok_t;

endpackage

// ----- src/zrld_front.sv -----
module zrld_front
    import zrld_pkg::*;
#(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        q_full,
    output logic        push,
    output zrld_tok_t   push_tok
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_ZCOUNT = 2'd1;
    localparam logic [1:0] PH_LCOUNT = 2'd2;
    localparam logic [1:0] PH_LITS   = 2'd3;

    localparam logic [2:0] HDR_LAST  = 3'(HEADER_BYTES - 1);
    localparam logic [3:0] VIDX_LAST = 4'(VARINT_MAX_BYTES - 1);
    localparam logic [OFFSET_WIDTH-1:0] OFS_ONE = {{(OFFSET_WIDTH-1){1'b0}}, 1'b1};

    logic [1:0]              phase_reg, phase_next;
    logic [2:0]              hdr_cnt_reg, hdr_cnt_next;
    logic [63:0]             hdr_val_reg, hdr_val_next;
    logic [63:0]             vval_reg, vval_next;
    logic [3:0]              vidx_reg, vidx_next;
    logic [63:0]             zrun_reg, zrun_next;
    logic [OFFSET_WIDTH-1:0] lits_left_reg, lits_left_next;
    logic [OFFSET_WIDTH-1:0] pos_reg, pos_next;
    logic [OFFSET_WIDTH-1:0] room_reg, room_next;
    logic [OFFSET_WIDTH-1:0] room2_reg, room2_next;
    logic                    zovf_reg, zovf_next;
    logic                    refresh_reg, refresh_next;
    logic [31:0]             bsize_reg, bsize_next;

    logic                    accept;
    logic                    restart;
    logic [63:0]             bs64, cw64, pos64;
    logic [OFFSET_WIDTH-1:0] size_now, cw_now, cfg_room;
    logic [6:0]              shamt;
    logic [63:0]             vfull, hdr_full, sub_op;
    logic [64:0]             diff;
    logic                    cont, overlong;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = !q_full && !cfg_valid && !refresh_reg;
    assign cfg_ready = 1'b1;

    assign bs64     = {32'd0, bsize_reg};
    assign size_now = bs64[OFFSET_WIDTH-1:0];
    assign cw64     = {32'd0, cfg_data};
    assign cw_now   = cw64[OFFSET_WIDTH-1:0];
    assign cfg_room = (cw_now > pos_reg) ? (cw_now - pos_reg) : '0;
    assign pos64    = 64'(pos_reg);

    assign shamt    = 7'(vidx_reg) * 7'(VARINT_STEP);
    assign vfull    = vval_reg | (64'(s_tdata[6:0]) << shamt);
    assign cont     = s_tdata[7];
    assign overlong = cont && (vidx_reg == VIDX_LAST);
    assign hdr_full = {s_tdata, hdr_val_reg[55:0]};

    assign sub_op = refresh_reg ? zrun_reg : vfull;
    assign diff   = {1'b0, 64'(room_reg)} - {1'b0, sub_op};

    always_comb begin
        phase_next     = phase_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        hdr_val_next   = hdr_val_reg;
        vval_next      = vval_reg;
        vidx_next      = vidx_reg;
        zrun_next      = zrun_reg;
        lits_left_next = lits_left_reg;
        pos_next       = pos_reg;
        room_next      = room_reg;
        room2_next     = room2_reg;
        zovf_next      = zovf_reg;
        refresh_next   = 1'b0;
        bsize_next     = bsize_reg;
        restart        = 1'b0;
        push           = 1'b0;
        push_tok       = '0;

        if (cfg_valid) begin
            bsize_next   = cfg_data;
            room_next    = cfg_room;
            refresh_next = 1'b1;
        end
        if (refresh_reg) begin
            room2_next = diff[OFFSET_WIDTH-1:0];
            zovf_next  = diff[64];
        end

        if (accept) begin
            if (s_tuser == OP_END) begin
                if (!(phase_reg == PH_HEADER && hdr_cnt_reg == '0)) begin
                    push         = 1'b1;
                    push_tok.kind = KIND_ERR;
                    push_tok.err  = ERR_TRUNC;
                    restart      = 1'b1;
                end
            end else begin
                unique case (phase_reg)
                    PH_HEADER: begin
                        hdr_val_next[{hdr_cnt_reg, 3'b000} +: 8] = s_tdata;
                        hdr_cnt_next = hdr_cnt_reg + 3'd1;
                        if (hdr_cnt_reg == HDR_LAST) begin
                            if (hdr_full == 64'(size_now)) begin
                                phase_next   = PH_ZCOUNT;
                                hdr_cnt_next = '0;
                                pos_next     = '0;
                                room_next    = size_now;
                                vval_next    = '0;
                                vidx_next    = '0;
                            end else begin
                                push          = 1'b1;
                                push_tok.kind = KIND_ERR;
                                push_tok.err  = ERR_HEADER;
                                restart       = 1'b1;
                            end
                        end
                    end
                    PH_ZCOUNT: begin
                        if (overlong) begin
                            push          = 1'b1;
                            push_tok.kind = KIND_ERR;
                            push_tok.err  = ERR_OVERLONG;
                            restart       = 1'b1;
                        end else if (!cont) begin
                            zrun_next  = vfull;
                            vval_next  = '0;
                            vidx_next  = '0;
                            room2_next = diff[OFFSET_WIDTH-1:0];
                            zovf_next  = diff[64];
                            phase_next = PH_LCOUNT;
                        end else begin
                            vval_next = vfull;
                            vidx_next = vidx_reg + 4'd1;
                        end
                    end
                    PH_LCOUNT: begin
                        if (overlong) begin
                            push          = 1'b1;
                            push_tok.kind = KIND_ERR;
                            push_tok.err  = ERR_OVERLONG;
                            restart       = 1'b1;
                        end else if (!cont) begin
                            vval_next = '0;
                            vidx_next = '0;
                            push      = 1'b1;
                            if (zrun_reg == '0 && vfull == '0) begin
                                if (pos_reg == size_now) begin
                                    push_tok.kind = KIND_DONE;
                                end else begin
                                    push_tok.kind = KIND_ERR;
                                    push_tok.err  = ERR_SHORT;
                                end
                                restart = 1'b1;
                            end else if (zovf_reg) begin
                                push_tok.kind = KIND_ERR;
                                push_tok.err  = ERR_ZERO_OVF;
                                restart       = 1'b1;
                            end else if (vfull > 64'(room2_reg)) begin
                                push_tok.kind = KIND_ERR;
                                push_tok.err  = ERR_LIT_OVF;
                                restart       = 1'b1;
                            end else begin
                                push_tok.kind   = KIND_FILL;
                                push_tok.offset = pos64[31:0];
                                push_tok.count  = zrun_reg[31:0];
                                pos_next        = pos_reg + zrun_reg[OFFSET_WIDTH-1:0];
                                room_next       = room2_reg;
                                lits_left_next  = vfull[OFFSET_WIDTH-1:0];
                                zrun_next       = '0;
                                phase_next      = (vfull != '0) ? PH_LITS : PH_ZCOUNT;
                            end
                        end else begin
                            vval_next = vfull;
                            vidx_next = vidx_reg + 4'd1;
                        end
                    end
                    PH_LITS: begin
                        push            = 1'b1;
                        push_tok.kind   = KIND_LIT;
                        push_tok.offset = pos64[31:0];
                        push_tok.count  = 32'd1;
                        push_tok.data   = s_tdata;
                        pos_next        = pos_reg + OFS_ONE;
                        room_next       = (room_reg == '0) ? '0 : (room_reg - OFS_ONE);
                        lits_left_next  = lits_left_reg - OFS_ONE;
                        if (lits_left_reg == OFS_ONE) begin
                            phase_next = PH_ZCOUNT;
                        end
                    end
                    default: begin
                        phase_next = PH_HEADER;
                    end
                endcase
            end
        end

        if (restart) begin
            phase_next     = PH_HEADER;
            hdr_cnt_next   = '0;
            hdr_val_next   = '0;
            vval_next      = '0;
            vidx_next      = '0;
            zrun_next      = '0;
            lits_left_next = '0;
            pos_next       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            hdr_cnt_reg   <= '0;
            hdr_val_reg   <= '0;
            vval_reg      <= '0;
            vidx_reg      <= '0;
            zrun_reg      <= '0;
            lits_left_reg <= '0;
            pos_reg       <= '0;
            room_reg      <= '0;
            room2_reg     <= '0;
            zovf_reg      <= 1'b0;
            refresh_reg   <= 1'b0;
            bsize_reg     <= '0;
        end else begin
            phase_reg     <= phase_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            hdr_val_reg   <= hdr_val_next;
            vval_reg      <= vval_next;
            vidx_reg      <= vidx_next;
            zrun_reg      <= zrun_next;
            lits_left_reg <= lits_left_next;
            pos_reg       <= pos_next;
            room_reg      <= room_next;
            room2_reg     <= room2_next;
            zovf_reg      <= zovf_next;
            refresh_reg   <= refresh_next;
            bsize_reg     <= bsize_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (s_tvalid && s_tready))
        else $error("front pushed an item without an accepted input");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_LITS) |-> (lits_left_reg != '0))
        else $error("literal phase with no literals left");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |=> (refresh_reg && bsize_reg == $past(cfg_data)))
        else $error("block size write not followed by room refresh");

endmodule

// ----- src/zrld_queue.sv -----
module zrld_queue
    import zrld_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  zrld_tok_t push_tok,
    output logic      full,
    input  logic      pop,
    output zrld_tok_t pop_tok,
    output logic      empty
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    zrld_tok_t       mem_reg [QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [AW:0]     count_reg, count_next;

    assign full    = (count_reg == (AW+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_tok = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? (wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? (rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_tok;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop))
        else $error("push into a full queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (AW+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

// ----- src/zrld_back.sv -----
module zrld_back
    import zrld_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_empty,
    input  zrld_tok_t            q_tok,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser
);

    logic      out_valid_reg, out_valid_next;
    zrld_tok_t out_tok_reg, out_tok_next;
    zrld_tok_t fmt;
    logic      is_cmd;

    assign pop = !q_empty && (!out_valid_reg || m_tready);

    always_comb begin
        is_cmd = (q_tok.kind == KIND_LIT) || (q_tok.kind == KIND_FILL);
        fmt        = q_tok;
        fmt.offset = is_cmd ? q_tok.offset : 32'd0;
        fmt.count  = is_cmd ? q_tok.count : 32'd0;
        fmt.data   = (q_tok.kind == KIND_LIT) ? q_tok.data : 8'd0;
        fmt.err    = (q_tok.kind == KIND_ERR) ? q_tok.err : ERR_NONE;

        out_valid_next = out_valid_reg;
        out_tok_next   = out_tok_reg;
        if (pop) begin
            out_valid_next = 1'b1;
            out_tok_next   = fmt;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_tok_reg <= out_tok_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_tok_reg.data, out_tok_reg.count, out_tok_reg.offset};
    assign m_tuser  = {out_tok_reg.err, out_tok_reg.kind};

    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_tok_reg.kind == KIND_DONE || out_tok_reg.kind == KIND_ERR))
        |-> (out_tok_reg.offset == 32'd0 && out_tok_reg.count == 32'd0))
        else $error("status item carries an offset or a length");

endmodule

// ----- src/zero_run_literal_decoder_top.sv -----
// Channel   Direction  Handshake              Payload
// s_        in         s_tvalid / s_tready    s_tdata: in_byte; s_tuser: opcode
// m_        out        m_tvalid / m_tready    m_tdata: address, length, data;
//                                             m_tuser: result_kind, error_code
// cfg_      in         cfg_valid / cfg_ready  cfg_data: block_size
//
// One encoded byte is taken per cycle while s_tready is high; its result goes on m_ through
// a four-entry queue, written at the accepting edge, and then the output register.
// A block_size write holds s_tready low in the write cycle and the cycle after,
// while the remaining-space registers are recomputed.
// Reset is synchronous on aresetn: header phase, block_size zero, queue empty.
// A stalled m_ side fills the queue; s_tready also drops when the queue is full.
module zero_run_literal_decoder_top
    import zrld_pkg::*;
#(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] in_byte
    input  logic                 s_tuser,   // [0] opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] address, [63:32] length, [71:64] data
    output logic [M_TUSER_W-1:0] m_tuser,   // [1:0] result_kind, [4:2] error_code
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [31:0]          cfg_data
);

    zrld_tok_t push_tok;
    zrld_tok_t pop_tok;
    logic      push;
    logic      pop;
    logic      q_full;
    logic      q_empty;

    zrld_front #(
        .OFFSET_WIDTH(OFFSET_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .push_tok  (push_tok)
    );

    zrld_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_tok (push_tok),
        .full     (q_full),
        .pop      (pop),
        .pop_tok  (pop_tok),
        .empty    (q_empty)
    );

    zrld_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_tok    (pop_tok),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- bench/zrld_decode_checker.sv -----
`timescale 1ns / 100ps

module zrld_decode_checker
    import zrld_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] in_byte
    input  logic                 s_tuser,   // [0] opcode
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // [31:0] address, [63:32] length, [71:64] data
    input  logic [M_TUSER_W-1:0] m_tuser,   // [1:0] result_kind, [4:2] error_code
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [31:0]          cfg_data,
    output int                   mismatches,
    output int                   pending,
    output int                   results_seen,
    output int                   error_reports
);

    localparam logic [63:0] OFF_MASK = (64'd1 << OFFSET_WIDTH_DEF) - 64'd1;

    typedef enum logic [1:0] {PH_HDR, PH_ZCNT, PH_LCNT, PH_LITS} dec_phase_t;

    dec_phase_t  ph;
    logic [3:0]  hdr_cnt;
    logic [63:0] hdr_val;
    logic [63:0] vint;
    logic [6:0]  vshift;
    logic [63:0] zrun;
    logic [63:0] lits_left;
    logic [63:0] pos;
    logic [31:0] size_reg;
    zrld_tok_t   decoded_q[$];
    int          bad = 0;
    int          seen = 0;
    int          errs = 0;

    function automatic logic [63:0] size_now();
        return {32'b0, size_reg} & OFF_MASK;
    endfunction

    function automatic logic [63:0] room();
        return (size_now() > pos) ? size_now() - pos : 64'd0;
    endfunction

    task automatic restart();
        ph        = PH_HDR;
        hdr_cnt   = '0;
        hdr_val   = '0;
        vint      = '0;
        vshift    = '0;
        zrun      = '0;
        lits_left = '0;
        pos       = '0;
    endtask

    task automatic post(input logic [1:0] kind, input logic [63:0] at, input logic [63:0] len,
                        input logic [7:0] bt, input logic [2:0] code);
        zrld_tok_t t;
        t.kind   = kind;
        t.err    = code;
        t.offset = at[31:0];
        t.count  = len[31:0];
        t.data   = bt;
        decoded_q.push_back(t);
        if (kind == KIND_DONE || kind == KIND_ERR) begin
            restart();
        end
    endtask

    // r: 1 count complete, -1 overlong, 0 more bytes to come
    task automatic take_varint(input logic [7:0] b, output int r);
        if (vshift < 7'd64) begin
            vint = vint | (64'(b[6:0]) << vshift);
        end
        if (!b[7]) begin
            r = 1;
        end else begin
            vshift = vshift + 7'(VARINT_STEP);
            r = (vshift >= 7'd64) ? -1 : 0;
        end
    endtask

    task automatic decode_byte(input logic op, input logic [7:0] b);
        logic [63:0] lits;
        logic [63:0] start;
        logic [63:0] at;
        int          r;
        if (op == OP_END) begin
            if (!(ph == PH_HDR && hdr_cnt == 0)) begin
                post(KIND_ERR, 0, 0, 0, ERR_TRUNC);
            end
        end else begin
            case (ph)
                PH_HDR: begin
                    hdr_val = hdr_val | (64'(b) << (hdr_cnt[2:0] * 8));
                    hdr_cnt = hdr_cnt + 4'd1;
                    if (hdr_cnt == 4'(HEADER_BYTES)) begin
                        if (hdr_val != size_now()) begin
                            post(KIND_ERR, 0, 0, 0, ERR_HEADER);
                        end else begin
                            hdr_cnt = '0;
                            hdr_val = '0;
                            pos     = '0;
                            vint    = '0;
                            vshift  = '0;
                            ph      = PH_ZCNT;
                        end
                    end
                end
                PH_ZCNT: begin
                    take_varint(b, r);
                    if (r < 0) begin
                        post(KIND_ERR, 0, 0, 0, ERR_OVERLONG);
                    end else if (r > 0) begin
                        zrun   = vint;
                        vint   = '0;
                        vshift = '0;
                        ph     = PH_LCNT;
                    end
                end
                PH_LCNT: begin
                    take_varint(b, r);
                    if (r < 0) begin
                        post(KIND_ERR, 0, 0, 0, ERR_OVERLONG);
                    end else if (r > 0) begin
                        lits   = vint;
                        vint   = '0;
                        vshift = '0;
                        if (zrun == 0 && lits == 0) begin
                            if (pos == size_now()) begin
                                post(KIND_DONE, 0, 0, 0, ERR_NONE);
                            end else begin
                                post(KIND_ERR, 0, 0, 0, ERR_SHORT);
                            end
                        end else if (zrun > room()) begin
                            post(KIND_ERR, 0, 0, 0, ERR_ZERO_OVF);
                        end else begin
                            start = pos;
                            pos   = pos + zrun;
                            if (lits > room()) begin
                                post(KIND_ERR, 0, 0, 0, ERR_LIT_OVF);
                            end else begin
                                lits_left = lits;
                                ph        = (lits != 0) ? PH_LITS : PH_ZCNT;
                                post(KIND_FILL, start, zrun, 0, ERR_NONE);
                                zrun = '0;
                            end
                        end
                    end
                end
                default: begin
                    at  = pos;
                    pos = (pos + 64'd1) & OFF_MASK;
                    if (lits_left != 0) begin
                        lits_left = lits_left - 64'd1;
                    end
                    if (lits_left == 0) begin
                        ph = PH_ZCNT;
                    end
                    post(KIND_LIT, at, 64'd1, b, ERR_NONE);
                end
            endcase
        end
    endtask

    task automatic report(input string field, input logic [31:0] want_v, input logic [31:0] got_v);
        bad++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want_v, got_v);
    endtask

    always @(posedge aclk) begin : watch
        zrld_tok_t want;
        if (!aresetn) begin
            size_reg = '0;
            restart();
            decoded_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                seen++;
                if (m_tuser[1:0] == KIND_ERR) begin
                    errs++;
                end
                if (decoded_q.size() == 0) begin
                    bad++;
                    $display("%0t: result with none expected: kind %0d address %0h length %0h",
                             $time, m_tuser[1:0], m_tdata[31:0], m_tdata[63:32]);
                end else begin
                    want = decoded_q.pop_front();
                    if (m_tuser[1:0] !== want.kind) begin
                        report("result_kind", want.kind, m_tuser[1:0]);
                    end
                    if (m_tuser[4:2] !== want.err) begin
                        report("error_code", want.err, m_tuser[4:2]);
                    end
                    if (m_tdata[31:0] !== want.offset) begin
                        report("address", want.offset, m_tdata[31:0]);
                    end
                    if (m_tdata[63:32] !== want.count) begin
                        report("length", want.count, m_tdata[63:32]);
                    end
                    if (m_tdata[71:64] !== want.data) begin
                        report("data", want.data, m_tdata[71:64]);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                size_reg = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                decode_byte(s_tuser, s_tdata);
            end
        end
        mismatches    <= bad;
        pending       <= decoded_q.size();
        results_seen  <= seen;
        error_reports <= errs;
    end

endmodule

// ----- bench/zero_run_literal_decoder_top_test.sv -----
`timescale 1ns / 100ps

module zero_run_literal_decoder_top_test;
    import zrld_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_ITEMS = 220;
    localparam int NUM_PHASES  = 8;

    typedef enum int {
        FLAW_NONE, FLAW_HEADER, FLAW_TRUNC, FLAW_OVERLONG,
        FLAW_ZERO_OVF, FLAW_LIT_OVF, FLAW_SHORT, FLAW_NOISE
    } flaw_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic                 s_tuser   = OP_DATA;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [31:0]          cfg_data  = '0;

    int          mismatches;
    int          pending;
    int          results_seen;
    int          error_reports;
    int          items_sent    = 0;
    int          settings_used = 0;
    int          quiet_cycles  = 0;
    int          sink_wait     = 0;
    int          sink_draw;
    bit          no_gaps       = 1'b0;
    logic [31:0] cur_size      = '0;
    logic [31:0] room_left;

    zero_run_literal_decoder_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    zrld_decode_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending       (pending),
        .results_seen  (results_seen),
        .error_reports (error_reports)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_wait <= 0;
        end else if (m_tvalid && m_tready) begin
            sink_draw = no_gaps ? 0 : $urandom_range(8, 0);
            sink_wait <= sink_draw;
            m_tready  <= (sink_draw == 0);
        end else if (sink_wait != 0) begin
            sink_wait <= sink_wait - 1;
            m_tready  <= (sink_wait == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_item(input logic op, input logic [7:0] b);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(8, 0);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    function automatic int pad_bytes();
        return ($urandom_range(7, 0) == 0) ? $urandom_range(3, 1) : 0;
    endfunction

    // LEB128, optionally stretched with redundant continuation bytes
    task automatic send_count(input logic [63:0] v, input int pad);
        logic [7:0] bt;
        int         k;
        do begin
            bt = {1'b0, v[6:0]};
            v  = v >> VARINT_STEP;
            if (v != 0 || pad != 0) begin
                bt[7] = 1'b1;
            end
            send_item(OP_DATA, bt);
        end while (v != 0);
        for (k = 1; k <= pad; k++) begin
            send_item(OP_DATA, (k == pad) ? 8'h00 : 8'h80);
        end
    endtask

    task automatic send_header(input logic [63:0] hv, input int n);
        int k;
        for (k = 0; k < n; k++) begin
            send_item(OP_DATA, hv[k*8 +: 8]);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_block_size(input logic [31:0] v);
        wait_drained();
        repeat (6) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cur_size = v;
        settings_used++;
    endtask

    task automatic send_good_pair();
        logic [31:0] z;
        logic [31:0] l;
        logic [31:0] zmax;
        l    = $urandom_range((room_left < 5) ? room_left : 5, 0);
        zmax = room_left - l;
        if ($urandom_range(1, 0) == 0) begin
            z = $urandom_range((zmax < 8) ? zmax : 8, 0);
        end else begin
            z = zmax - $urandom_range((zmax < 3) ? zmax : 3, 0);
        end
        if (z == 0 && l == 0) begin
            z = 1;
        end
        send_count({32'b0, z}, pad_bytes());
        send_count({32'b0, l}, pad_bytes());
        repeat (l) send_item(OP_DATA, 8'($urandom_range(255, 0)));
        room_left = room_left - z - l;
    endtask

    task automatic run_block();
        logic [63:0] hv;
        logic [63:0] z;
        logic [63:0] l;
        flaw_t       flaw;
        int          where;
        int          good_pairs;
        int          k;
        int          n;
        flaw  = ($urandom_range(9, 0) < 7) ? FLAW_NONE : flaw_t'($urandom_range(7, 1));
        where = $urandom_range(3, 0);
        if (flaw == FLAW_NOISE) begin
            n = $urandom_range(12, 1);
            for (k = 0; k < n; k++) begin
                send_item(($urandom_range(5, 0) == 0) ? OP_END : OP_DATA,
                          8'($urandom_range(255, 0)));
            end
            send_item(OP_END, 8'($urandom_range(255, 0)));
        end else begin
            hv = {32'b0, cur_size};
            if (flaw == FLAW_HEADER) begin
                hv = hv ^ (64'd1 << $urandom_range(63, 0));
            end
            n = (flaw == FLAW_TRUNC && where == 0) ? $urandom_range(HEADER_BYTES - 1, 1)
                                                   : HEADER_BYTES;
            send_header(hv, n);
            if (n < HEADER_BYTES) begin
                send_item(OP_END, 8'($urandom_range(255, 0)));
            end else if (flaw != FLAW_HEADER) begin
                room_left  = cur_size;
                good_pairs = $urandom_range(4, 0);
                k = 0;
                while (room_left != 0 && (flaw == FLAW_NONE || k < good_pairs)) begin
                    send_good_pair();
                    k++;
                end
                case (flaw)
                    FLAW_NONE, FLAW_SHORT: begin
                        send_count(64'd0, pad_bytes());
                        send_count(64'd0, pad_bytes());
                    end
                    FLAW_TRUNC: begin
                        if (where == 2) begin
                            send_item(OP_DATA, 8'h80 | 8'($urandom_range(127, 0)));
                        end else if (where == 3 && room_left != 0) begin
                            l = (room_left < 3) ? room_left : 3;
                            send_count(64'd0, 0);
                            send_count(l, 0);
                            repeat (l - 1) send_item(OP_DATA, 8'($urandom_range(255, 0)));
                        end
                        send_item(OP_END, 8'($urandom_range(255, 0)));
                    end
                    FLAW_OVERLONG: begin
                        if (where % 2 == 1) begin
                            send_count(64'($urandom_range(3, 0)), 0);
                        end
                        repeat (VARINT_MAX_BYTES) begin
                            send_item(OP_DATA, 8'h80 | 8'($urandom_range(127, 0)));
                        end
                    end
                    FLAW_ZERO_OVF: begin
                        if (where == 3) begin
                            // ten-byte count: payload bits above bit 63 drop
                            repeat (VARINT_MAX_BYTES - 1) send_item(OP_DATA, 8'hFF);
                            send_item(OP_DATA, 8'($urandom_range(127, 0)));
                        end else begin
                            send_count({32'b0, room_left} + 64'($urandom_range(3, 1)),
                                       pad_bytes());
                        end
                        send_count(64'($urandom_range(4, 0)), 0);
                    end
                    FLAW_LIT_OVF: begin
                        z = 64'($urandom_range(room_left, 0));
                        send_count(z, pad_bytes());
                        send_count({32'b0, room_left} - z + 64'($urandom_range(3, 1)),
                                   pad_bytes());
                    end
                    default: ;
                endcase
            end
        end
    endtask

    function automatic logic [31:0] phase_size(input int p);
        case (p)
            0:       return 32'd1;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(48, 2);
            3:       return 32'd0;
            4:       return 32'h8000_0000;
            5:       return $urandom;
            6:       return $urandom_range(400, 49);
            default: return $urandom_range(16, 2);
        endcase
    endfunction

    initial begin
        int p;
        int target;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // idle end of stream, then an empty block at the reset size
        send_item(OP_END, 8'hA5);
        send_header(64'd0, HEADER_BYTES);
        send_count(64'd0, 0);
        send_count(64'd0, 0);

        // shrink the block below the current position mid-block
        write_block_size(32'd12);
        send_header(64'd12, HEADER_BYTES);
        send_count(64'd5, 1);
        send_count(64'd0, 0);
        write_block_size(32'd3);
        send_count(64'd0, 0);
        send_count(64'd1, 0);

        // truncated header
        send_header(64'd3, 1);
        send_item(OP_END, 8'hFF);

        for (p = 0; p < NUM_PHASES; p++) begin
            write_block_size(phase_size(p));
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                no_gaps <= ($urandom_range(3, 0) == 0);
                if ($urandom_range(7, 0) == 0) begin
                    wait_drained();
                end
                if ($urandom_range(15, 0) == 0) begin
                    send_item(OP_END, 8'($urandom_range(255, 0)));
                end
                run_block();
            end
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (pending != 0) begin
            $display("%0t: %0d decoder results never arrived", $time, pending);
        end
        $display("Covered %0d input items under %0d block_size settings.",
                 items_sent, settings_used);
        $display("Checked %0d decoder results, %0d of them error reports.",
                 results_seen, error_reports);
        if (mismatches == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
